/* sv/sdba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdba_pkg: shared types and constants for the sliding day bucket accumulator
// Window size, slot and counter widths, item codes, controller states and
// the request word that drives the bucket store.
// ----------------------------------------------------------------------------
package sdba_pkg;

	localparam int WINDOW_DAYS = 1024;
	localparam int SLOT_W      = $clog2(WINDOW_DAYS);
	localparam int CNT_W       = $clog2(WINDOW_DAYS + 1);
	localparam int BUCKET_W    = 8;

	localparam logic [BUCKET_W-1:0] SAT_MAX   = 8'd255;
	localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(WINDOW_DAYS - 1);

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SLIDE,
		ST_READ,
		ST_MOD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                we;
		logic [SLOT_W-1:0]   waddr;
		logic [BUCKET_W-1:0] wdata;
		logic                re;
		logic [SLOT_W-1:0]   raddr;
	} ram_req_t;

endpackage

/* sv/sdba_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdba_ram: bucket store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sdba_ram (
	input  logic                                clk,
	input  sdba_pkg::ram_req_t                  req,
	output logic [sdba_pkg::BUCKET_W-1:0]       rd_data
);
	import sdba_pkg::*;

	logic [BUCKET_W-1:0] mem_q [WINDOW_DAYS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem_q[req.raddr];
		end
	end

endmodule

/* sv/sliding_day_bucket_accumulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_day_bucket_accumulator: per-day saturating counters over a window
// Ring of 8-bit day counters anchored at the newest day seen, with add and
// query items and one result word per item.
// ----------------------------------------------------------------------------
// Usage: each input word is an add (tuser 0) or a query (tuser 1) of one
// day. The counters live in a single-port-read, single-port-write memory,
// so every item reads one bucket and an add writes it back. A result
// word is built by the decode, read, modify and output steps in that
// order, where the read step covers the registered memory read. s_tready
// returns once the output step is done, so a new item is taken only after
// the last one has left the output step. An add that slides the window by
// span days sweeps the vacated buckets and drains the last zero write
// before the read step. An add that anchors an empty window, or slides it
// by a whole window or more, clears the entire store. After reset the same
// clearing pass runs before s_tready rises. One result word may wait in
// the output register while the next word is taken; the output step holds
// until that register is free.
// ----------------------------------------------------------------------------
module sliding_day_bucket_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] day_number, [47:32] amount
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [7:0] day_count, [8] dropped, [9] any_data,
	                               // [41:10] newest_day_out, [47:42] zero
);
	import sdba_pkg::*;

	state_t              state_q, state_d;
	ram_req_t            req;
	logic [BUCKET_W-1:0] rd_data;

	// item and window state
	logic                mode_q;
	logic [31:0]         day_q;
	logic [15:0]         amt_q;
	logic                busy_q;
	logic [31:0]         newest_q;
	logic [SLOT_W-1:0]   head_q;
	logic [CNT_W-1:0]    nz_q;

	// clearing and slide sweeps
	logic [SLOT_W-1:0]   clr_idx_q;
	logic [SLOT_W-1:0]   left_q;
	logic [SLOT_W-1:0]   sw_idx_q;
	logic                pend_s1;
	logic [SLOT_W-1:0]   pend_addr_s1;

	// target bucket and result
	logic                win_q;
	logic                hit_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [BUCKET_W-1:0] cnt_q;
	logic                drop_q;
	logic                m_valid_q;
	logic [47:0]         m_data_q;

	logic                in_acc;
	logic                out_load;

	sdba_ram u_ram (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------------------
	// decode of the held item against the window
	// ------------------------------------------------------------------
	logic                is_add;
	logic                newer;
	logic [31:0]         span;
	logic                span_long;
	logic [SLOT_W-1:0]   span_s;
	logic [SLOT_W:0]     head_diff;
	logic [SLOT_W:0]     head_wrap;
	logic [SLOT_W-1:0]   head_back;

	assign is_add    = (mode_q == MODE_ADD) && (amt_q != 16'd0);
	assign newer     = day_q > newest_q;
	assign span      = day_q - newest_q;
	assign span_long = span >= 32'(WINDOW_DAYS);
	assign span_s    = span[SLOT_W-1:0];
	assign head_diff = {1'b0, head_q} - {1'b0, span_s};
	// step the head back by span, wrapping modulo the window
	assign head_wrap = head_diff[SLOT_W] ? head_diff + (SLOT_W+1)'(WINDOW_DAYS) : head_diff;
	assign head_back = head_wrap[SLOT_W-1:0];

	// ------------------------------------------------------------------
	// target slot: offset of the day behind the anchor
	// ------------------------------------------------------------------
	logic [32:0]         dwide;
	logic                no_borrow;
	logic                in_win;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   slot_tgt;

	assign dwide     = {1'b0, newest_q} - {1'b0, day_q};
	assign no_borrow = !dwide[32];
	assign in_win    = dwide[31:0] < 32'(WINDOW_DAYS);
	assign slot_sum  = {1'b0, head_q} + {1'b0, dwide[SLOT_W-1:0]};
	assign slot_tgt  = (slot_sum >= (SLOT_W+1)'(WINDOW_DAYS))
		? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_DAYS)) : slot_sum[SLOT_W-1:0];

	// saturating add on the bucket read back
	logic [16:0]         sum;
	logic [BUCKET_W-1:0] sat;

	assign sum = {9'd0, rd_data} + {1'b0, amt_q};
	assign sat = (sum > 17'(SAT_MAX)) ? SAT_MAX : sum[BUCKET_W-1:0];

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == LAST_SLOT) begin
					state_d = busy_q ? ST_READ : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (is_add && (newest_q == 32'd0)) begin
					state_d = ST_CLEAR;
				end else if (is_add && newer) begin
					state_d = span_long ? ST_CLEAR : ST_SLIDE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_SLIDE: begin
				// leave only once the last zero write has landed
				if ((left_q == '0) && !pend_s1) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_MOD;
			ST_MOD:  state_d = ST_OUT;
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// outputs of the controller: store requests and handshakes
	// ------------------------------------------------------------------
	always_comb begin
		req      = '0;
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				req.we    = 1'b1;
				req.waddr = clr_idx_q;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SLIDE: begin
				// read one slot ahead, zero the slot read last cycle
				req.re    = left_q != '0;
				req.raddr = sw_idx_q;
				req.we    = pend_s1;
				req.waddr = pend_addr_s1;
			end
			ST_READ: begin
				req.re    = 1'b1;
				req.raddr = slot_tgt;
			end
			ST_MOD: begin
				req.we    = is_add && win_q;
				req.waddr = slot_q;
				req.wdata = sat;
			end
			ST_OUT: begin
				out_load = !m_valid_q || m_tready;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	assign in_acc = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			busy_q    <= 1'b0;
			newest_q  <= 32'd0;
			head_q    <= '0;
			nz_q      <= '0;
			left_q    <= '0;
			sw_idx_q  <= '0;
			pend_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				busy_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= (clr_idx_q == LAST_SLOT) ? '0 : clr_idx_q + SLOT_W'(1);
				end
				ST_DECODE: begin
					if (is_add && (newest_q == 32'd0)) begin
						// anchor an empty window
						newest_q  <= day_q;
						head_q    <= '0;
						nz_q      <= '0;
						clr_idx_q <= '0;
					end else if (is_add && newer) begin
						newest_q <= day_q;
						if (span_long) begin
							head_q    <= '0;
							nz_q      <= '0;
							clr_idx_q <= '0;
						end else begin
							head_q   <= head_back;
							left_q   <= span_s;
							sw_idx_q <= head_back;
						end
					end
				end
				ST_SLIDE: begin
					if (left_q != '0) begin
						left_q   <= left_q - SLOT_W'(1);
						sw_idx_q <= (sw_idx_q == LAST_SLOT) ? '0 : sw_idx_q + SLOT_W'(1);
						pend_s1  <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && (rd_data != '0)) begin
						nz_q <= nz_q - CNT_W'(1);
					end
				end
				ST_MOD: begin
					// the sum is nonzero, so only a zero bucket changes the count
					if (is_add && win_q && (rd_data == '0)) begin
						nz_q <= nz_q + CNT_W'(1);
					end
				end
				ST_OUT: begin
					if (out_load) begin
						busy_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= s_tuser;
			day_q  <= s_tdata[31:0];
			amt_q  <= s_tdata[47:32];
		end
		if (state_q == ST_SLIDE) begin
			pend_addr_s1 <= sw_idx_q;
		end
		if (state_q == ST_READ) begin
			slot_q <= slot_tgt;
			win_q  <= no_borrow && in_win;
			hit_q  <= no_borrow && in_win && (newest_q != 32'd0);
		end
		if (state_q == ST_MOD) begin
			cnt_q  <= hit_q ? (is_add ? sat : rd_data) : '0;
			drop_q <= is_add && !win_q;
		end
		if (out_load) begin
			m_data_q <= {6'd0, newest_q, (newest_q != 32'd0) && (nz_q != '0), drop_q, cnt_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_nz_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nz_q <= CNT_W'(WINDOW_DAYS))
		else $error("nonzero bucket count exceeds window");

	a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re && (req.waddr == req.raddr)))
		else $error("read and write of the same bucket in one cycle");

	a_sweep_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !pend_s1)
		else $error("target read issued before slide sweep drained");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word raised outside the output step");

	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !busy_q)
		else $error("idle with an item still in flight");

endmodule
